// ----- hdl/chained_hash_table_defines.svh -----
// Assertion macros shared by the hash table modules
`ifndef CHAINED_HASH_TABLE_DEFINES_SVH
`define CHAINED_HASH_TABLE_DEFINES_SVH
// Implication checked on every clock edge outside reset
`define CHT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication checked outside reset
`define CHT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ----- hdl/cht_pkg.sv -----
// Package: status codes, operation codes, key and value widths and engine states of the hash table
package cht_pkg;
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   localparam logic [1:0] ST_INSERTED  = 2'd0;
   localparam logic [1:0] ST_FOUND     = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   localparam int KEY_W = 16;
   localparam int VAL_W = 32;

   typedef enum logic [2:0] {
      ENG_IDLE,
      ENG_HEAD,
      ENG_NODE_RD,
      ENG_NODE_CMP,
      ENG_RESP
   } eng_state_type;
endpackage

// ----- hdl/cht_front.sv -----
// Front end: accept items and queue them for the engine
module cht_front
   import cht_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_operation,
   input  logic [KEY_W-1:0] req_key,
   input  logic [VAL_W-1:0] req_value,
   output logic             q_valid,
   input  logic             q_pop,
   output logic             q_operation,
   output logic [KEY_W-1:0] q_key,
   output logic [VAL_W-1:0] q_value
);
   `include "chained_hash_table_defines.svh"

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int ENTRY_W = 1 + KEY_W + VAL_W;

   logic [ENTRY_W-1:0] mem_ff [DEPTH];
   logic [AW-1:0]      wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [AW:0]        count_ff, count_in;
   logic               push, pop;

   // Stall when the queue is full
   assign req_stall = (count_ff == (AW+1)'(DEPTH));
   assign push      = req_valid && !req_stall;
   assign pop       = q_pop && (count_ff != '0);
   assign q_valid   = (count_ff != '0);
   assign {q_operation, q_key, q_value} = mem_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the accepted item
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= {req_operation, req_key, req_value};
      end
   end

   `CHT_ASSERT_IMP(a_count_range, clock, reset, 1'b1, count_ff <= (AW+1)'(DEPTH),
      "queue count beyond depth")
   `CHT_ASSERT_NEXT(a_push_only, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1,
      "queue count did not grow on push")
   `CHT_ASSERT_NEXT(a_pop_only, clock, reset, pop && !push, count_ff == $past(count_ff) - 1'b1,
      "queue count did not shrink on pop")
endmodule

// ----- hdl/cht_engine.sv -----
// Back end: insert into and walk the bucket chains, drive the result register
module cht_engine
   import cht_pkg::*;
#(
   parameter int BUCKETS = 16,
   parameter int NODES   = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   output logic             q_pop,
   input  logic             q_operation,
   input  logic [KEY_W-1:0] q_key,
   input  logic [VAL_W-1:0] q_value,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [VAL_W-1:0] rsp_found_value
);
   `include "chained_hash_table_defines.svh"

   localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int CW = $clog2(NODES + 1);

   // Bucket tables and node pool
   logic [BUCKETS-1:0] head_vld_ff;
   logic [NW-1:0]      head_idx_mem [BUCKETS];
   logic [NW-1:0]      tail_mem     [BUCKETS];
   logic [KEY_W-1:0]   key_mem      [NODES];
   logic [VAL_W-1:0]   val_mem      [NODES];
   logic [NW-1:0]      next_mem     [NODES];

   eng_state_type      state_ff, state_in;
   logic               op_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [VAL_W-1:0]   val_ff;
   logic [BW-1:0]      bkt_ff;
   logic [CW-1:0]      used_ff;
   logic [CW-1:0]      steps_ff;
   logic [NW-1:0]      idx_ff;
   logic               hv_rd_ff;
   logic [NW-1:0]      hi_rd_ff, tail_rd_ff;
   logic [KEY_W-1:0]   nkey_rd_ff;
   logic [VAL_W-1:0]   nval_rd_ff;
   logic [NW:0]        nnext_rd_ff;
   logic               out_vld_ff;
   logic [1:0]         out_st_ff;
   logic [VAL_W-1:0]   out_val_ff;
   logic               load, do_ins, full, walk_ok, set_rsp;
   logic [1:0]         rsp_code;
   logic [VAL_W-1:0]   rsp_data;

   assign load    = (state_ff == ENG_IDLE) && q_valid && !out_vld_ff;
   assign q_pop   = load;
   assign full    = (used_ff == CW'(NODES));
   assign do_ins  = (state_ff == ENG_HEAD) && (op_ff == OP_INSERT) && !full;
   assign walk_ok = steps_ff < CW'(NODES);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ENG_IDLE:     if (load) state_in = ENG_HEAD;
         ENG_HEAD: begin
            if (op_ff == OP_INSERT) state_in = ENG_RESP;
            else if (hv_rd_ff) state_in = ENG_NODE_RD;
            else state_in = ENG_RESP;
         end
         ENG_NODE_RD:  state_in = ENG_NODE_CMP;
         ENG_NODE_CMP: begin
            if (nkey_rd_ff == key_ff) state_in = ENG_RESP;
            else if (nnext_rd_ff[NW] && walk_ok) state_in = ENG_NODE_RD;
            else state_in = ENG_RESP;
         end
         ENG_RESP:     state_in = ENG_IDLE;
         default:      state_in = ENG_IDLE;
      endcase
   end

   // Outputs: result code from the current state
   always_comb begin
      set_rsp  = 1'b0;
      rsp_code = ST_NOT_FOUND;
      rsp_data = '0;
      case (state_ff)
         ENG_HEAD: begin
            if (op_ff == OP_INSERT) begin
               set_rsp  = 1'b1;
               rsp_code = full ? ST_FULL : ST_INSERTED;
            end else if (!hv_rd_ff) begin
               set_rsp = 1'b1;
            end
         end
         ENG_NODE_CMP: begin
            if (nkey_rd_ff == key_ff) begin
               set_rsp  = 1'b1;
               rsp_code = ST_FOUND;
               rsp_data = nval_rd_ff;
            end else if (!(nnext_rd_ff[NW] && walk_ok)) begin
               set_rsp = 1'b1;
            end
         end
         default: set_rsp = 1'b0;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ENG_IDLE;
         head_vld_ff <= '0;
         used_ff     <= '0;
         out_vld_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (set_rsp) begin
            out_vld_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_vld_ff <= 1'b0;
         end
         if (do_ins) begin
            used_ff <= used_ff + 1'b1;
            head_vld_ff[bkt_ff] <= 1'b1;
         end
      end
   end

   // Latch item, read bucket tables, keep walk index, capture the result
   always_ff @(posedge clock) begin
      if (load) begin
         op_ff    <= q_operation;
         key_ff   <= q_key;
         val_ff   <= q_value;
         bkt_ff   <= BW'(q_key % KEY_W'(BUCKETS));
         hv_rd_ff <= head_vld_ff[BW'(q_key % KEY_W'(BUCKETS))];
         hi_rd_ff   <= head_idx_mem[BW'(q_key % KEY_W'(BUCKETS))];
         tail_rd_ff <= tail_mem[BW'(q_key % KEY_W'(BUCKETS))];
      end
      if (state_ff == ENG_HEAD) begin
         idx_ff   <= hi_rd_ff;
         steps_ff <= '0;
      end else if (state_ff == ENG_NODE_CMP) begin
         idx_ff   <= nnext_rd_ff[NW-1:0];
         steps_ff <= steps_ff + 1'b1;
      end
      if (set_rsp) begin
         out_st_ff  <= rsp_code;
         out_val_ff <= rsp_data;
      end
   end

   // Write bucket tables and node pool on insert
   always_ff @(posedge clock) begin
      if (do_ins) begin
         key_mem[used_ff[NW-1:0]]  <= key_ff;
         val_mem[used_ff[NW-1:0]]  <= val_ff;
         tail_mem[bkt_ff]          <= used_ff[NW-1:0];
         if (!hv_rd_ff) begin
            head_idx_mem[bkt_ff] <= used_ff[NW-1:0];
         end
      end
   end

   // Link node pointers: old tail points to the new node
   always_ff @(posedge clock) begin
      if (do_ins && hv_rd_ff) begin
         next_mem[tail_rd_ff] <= used_ff[NW-1:0];
      end
   end

   // Clear link of a freshly used node, mark the old tail's link valid
   logic [NODES-1:0] link_vld_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         link_vld_ff <= '0;
      end else if (do_ins) begin
         link_vld_ff[used_ff[NW-1:0]] <= 1'b0;
         if (hv_rd_ff) begin
            link_vld_ff[tail_rd_ff] <= 1'b1;
         end
      end
   end

   // Read one node per step
   always_ff @(posedge clock) begin
      if (state_ff == ENG_NODE_RD) begin
         nkey_rd_ff  <= key_mem[idx_ff];
         nval_rd_ff  <= val_mem[idx_ff];
         nnext_rd_ff <= {link_vld_ff[idx_ff], next_mem[idx_ff]};
      end
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_status      = out_st_ff;
   assign rsp_found_value = out_val_ff;

   `CHT_ASSERT_IMP(a_used_range, clock, reset, 1'b1, used_ff <= CW'(NODES),
      "pool count beyond pool size")
   `CHT_ASSERT_IMP(a_load_idle, clock, reset, load, !out_vld_ff,
      "item taken while a result waits")
   `CHT_ASSERT_NEXT(a_hold_rsp, clock, reset, out_vld_ff && rsp_stall, out_vld_ff,
      "stalled result dropped")
   `CHT_ASSERT_IMP(a_found_data, clock, reset, out_vld_ff && out_st_ff != ST_FOUND,
      out_val_ff == '0, "value set for a result that is not found")
endmodule

// ----- hdl/chained_hash_table.sv -----
// Top level of the chained hash table
// Use: each request item carries an operation (insert or search), a key and
// a value. Every item gives exactly one response item with a status and, for
// a hit, the stored value. Inserts append to the tail of bucket key mod
// BUCKETS using the next free node of a NODES-entry pool; when the pool is
// full the insert is refused with the full status.
// Channels: req_ and rsp_ use valid and stall; an item moves on a rising edge
// with valid high and stall low. A two-entry queue sits in front of the
// engine, so requests are taken while the engine is busy.
// Path: an insert or a search of an empty bucket passes the queue, the engine
// item registers (state ENG_HEAD) and the response register; other searches
// visit the chain one node at a time, reading each node in ENG_NODE_RD and
// comparing it in ENG_NODE_CMP. The engine works on one item at a time.
// Reset clears the bucket head valid bits, the pool count, the queue and the
// response valid bit at once; no clearing pass is needed.
// When the receiver stalls the response holds and the engine takes no new
// item; the queue then fills and req_stall rises.
module chained_hash_table
   import cht_pkg::*;
#(
   parameter int BUCKETS = 16,
   parameter int NODES   = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_operation,
   input  logic [15:0]      req_key,
   input  logic [31:0]      req_value,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [31:0]      rsp_found_value
);
   logic             q_valid, q_pop, q_operation;
   logic [KEY_W-1:0] q_key;
   logic [VAL_W-1:0] q_value;

   cht_front #(.DEPTH(2)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_operation, .req_key,
      .req_value, .q_valid, .q_pop, .q_operation, .q_key, .q_value
   );

   cht_engine #(.BUCKETS(BUCKETS), .NODES(NODES)) u_engine (
      .clock, .reset, .q_valid, .q_pop, .q_operation, .q_key, .q_value,
      .rsp_valid, .rsp_stall, .rsp_status, .rsp_found_value
   );
endmodule
